// ----- hw/rtl/sspt_pkg.sv -----
// shared types and constants for the sorted slot page table
`default_nettype none
package sspt_pkg;
   typedef enum logic [1:0] {
      FUNC_READ   = 2'd0,
      FUNC_WRITE  = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;
   localparam int FUNC_WIDTH   = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int KEY_PORT     = 32;
   localparam int DATA_PORT    = 64;
   localparam int COUNT_PORT   = 6;
endpackage
`default_nettype wire

// ----- hw/rtl/sspt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module sspt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/sorted_slot_page_table_unit.sv -----
// sorted slot page table: top level with sequencer, directory and record memories
// One transaction is worked on at a time. A read or a delete is a binary search of the
// directory memory, whose single read port is registered; each probe passes through the
// states S_SRCH, S_SWAIT and S_SCMP. A write that inserts first shifts each directory entry
// above the insert point through S_SHRD, S_SHWAIT and S_SHWR. On a full page with tombstones
// a compaction walk comes first. It copies the live records into the other half of a record
// memory of twice CAPACITY entries. A finished result is held in an output register, so the
// next transaction is taken while it waits. The result after it waits in the sequencer until
// the first one has been handed over.
`default_nettype none
module sorted_slot_page_table_unit #(
   parameter int CAPACITY   = 32,
   parameter int DATA_WIDTH = 64,
   parameter int KEY_WIDTH  = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [103:0]  req_tdata, // func, key, data_in
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [79:0]        rsp_tdata  // status, read_data, entry_count, page_full, has_tombstone
);
   localparam int AW = $clog2(CAPACITY);
   localparam int RW = AW + 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = KEY_WIDTH + AW;
   localparam int SW = AW + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_CHK, S_CPRD, S_CPWAIT, S_CPWR, S_SRCH, S_SWAIT, S_SCMP,
      S_HIT, S_SHRD, S_SHWAIT, S_SHWR, S_INS, S_RDWAIT, S_RESP
   } state_type;

   state_type state_ff;
   logic [CAPACITY-1:0] live_ff;
   logic [CW-1:0] used_ff;
   logic [1:0] func_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic signed [SW-1:0] lo_ff, hi_ff;
   logic [AW-1:0] pos_ff;
   logic [CW-1:0] idx_ff, n_ff;
   logic [1:0] status_ff;
   logic [DATA_WIDTH-1:0] rd_ff;
   logic rvalid_ff;
   logic bank_ff;
   logic [79:0] rsp_data_ff;

   logic dwe, rwe;
   logic [AW-1:0] dwa, dra;
   logic [RW-1:0] rwa, rra;
   logic [DW-1:0] dwd, drd;
   logic [DATA_WIDTH-1:0] rwd, rrd;

   sspt_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_dir (
      .clock, .wr_en(dwe), .wr_addr(dwa), .wr_data(dwd), .rd_addr(dra), .rd_data(drd));
   sspt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(2 * CAPACITY)) u_rec (
      .clock, .wr_en(rwe), .wr_addr(rwa), .wr_data(rwd), .rd_addr(rra), .rd_data(rrd));

   logic [KEY_WIDTH-1:0] dkey;
   logic [AW-1:0] dslot;
   logic signed [SW-1:0] mid;
   logic tomb;
   logic [CAPACITY-1:0] inuse;
   assign dkey  = drd[DW-1:AW];
   assign dslot = drd[AW-1:0];
   assign mid   = lo_ff + ((hi_ff - lo_ff) >>> 1);
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) inuse[i] = (i < int'(used_ff));
   end
   assign tomb = |(inuse & ~live_ff);

   always_comb begin
      dwe = 1'b0; dwa = idx_ff[AW-1:0]; dwd = {dkey, dslot};
      dra = idx_ff[AW-1:0];
      rwe = 1'b0; rwa = {bank_ff, idx_ff[AW-1:0]}; rwd = rrd; rra = {bank_ff, dslot};
      unique case (state_ff)
         S_SRCH: dra = mid[AW-1:0];
         S_SWAIT, S_SCMP: dra = pos_ff;
         S_CPWR: begin
            dwe = 1'b1; dwa = n_ff[AW-1:0]; dwd = {dkey, n_ff[AW-1:0]};
            rwe = 1'b1; rwa = {~bank_ff, n_ff[AW-1:0]};
         end
         S_SHRD, S_SHWAIT: dra = AW'(idx_ff - 1'b1);
         S_SHWR: dwe = 1'b1;
         S_INS: begin
            dwe = 1'b1; dwa = pos_ff; dwd = {key_ff, used_ff[AW-1:0]};
            rwe = 1'b1; rwa = {bank_ff, used_ff[AW-1:0]}; rwd = data_ff;
         end
         S_HIT: begin
            rwa = {bank_ff, dslot}; rwd = data_ff;
            rwe = (func_ff == sspt_pkg::FUNC_WRITE) && !live_ff[pos_ff];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; live_ff <= '0; used_ff <= '0; rvalid_ff <= 1'b0;
         bank_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               func_ff <= req_tdata[1:0];
               key_ff <= KEY_WIDTH'(req_tdata[33:2]);
               data_ff <= DATA_WIDTH'(req_tdata[97:34]);
               status_ff <= sspt_pkg::ST_OK; rd_ff <= '0;
               state_ff <= S_CHK;
            end
            S_CHK: begin
               lo_ff <= '0; hi_ff <= SW'(used_ff) - 1'b1;
               if (func_ff == sspt_pkg::FUNC_NONE) state_ff <= S_RESP;
               else if (func_ff == sspt_pkg::FUNC_WRITE && used_ff >= CW'(CAPACITY)) begin
                  if (tomb) begin idx_ff <= '0; n_ff <= '0; state_ff <= S_CPRD; end
                  else begin status_ff <= sspt_pkg::ST_FULL; state_ff <= S_RESP; end
               end else state_ff <= S_SRCH;
            end
            S_CPRD: begin
               if (idx_ff == used_ff) begin
                  for (int i = 0; i < CAPACITY; i++) live_ff[i] <= (i < int'(n_ff));
                  used_ff <= n_ff; lo_ff <= '0; hi_ff <= SW'(n_ff) - 1'b1;
                  bank_ff <= ~bank_ff;
                  state_ff <= S_SRCH;
               end else if (live_ff[idx_ff[AW-1:0]]) state_ff <= S_CPWAIT;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_CPWAIT: state_ff <= S_CPWR;
            S_CPWR: begin
               n_ff <= n_ff + 1'b1; idx_ff <= idx_ff + 1'b1; state_ff <= S_CPRD;
            end
            S_SRCH: begin
               if (lo_ff > hi_ff) begin
                  pos_ff <= lo_ff[AW-1:0];
                  if (func_ff == sspt_pkg::FUNC_WRITE) begin
                     idx_ff <= used_ff; state_ff <= S_SHRD;
                  end else begin
                     status_ff <= sspt_pkg::ST_NOT_FOUND; state_ff <= S_RESP;
                  end
               end else begin
                  pos_ff <= mid[AW-1:0]; state_ff <= S_SWAIT;
               end
            end
            S_SWAIT: state_ff <= S_SCMP;
            S_SCMP: begin
               if (dkey == key_ff) state_ff <= S_HIT;
               else begin
                  if (dkey < key_ff) lo_ff <= SW'(pos_ff) + 1'b1;
                  else hi_ff <= SW'(pos_ff) - 1'b1;
                  state_ff <= S_SRCH;
               end
            end
            S_HIT: begin
               if (!live_ff[pos_ff]) begin
                  if (func_ff == sspt_pkg::FUNC_WRITE) live_ff[pos_ff] <= 1'b1;
                  else status_ff <= sspt_pkg::ST_NOT_FOUND;
                  state_ff <= S_RESP;
               end else unique case (func_ff)
                  sspt_pkg::FUNC_WRITE: begin
                     status_ff <= sspt_pkg::ST_DUPLICATE; state_ff <= S_RESP;
                  end
                  sspt_pkg::FUNC_DELETE: begin
                     live_ff[pos_ff] <= 1'b0; state_ff <= S_RESP;
                  end
                  default: state_ff <= S_RDWAIT;
               endcase
            end
            S_RDWAIT: begin rd_ff <= rrd; state_ff <= S_RESP; end
            S_SHRD: begin
               if (idx_ff == CW'(pos_ff)) state_ff <= S_INS;
               else state_ff <= S_SHWAIT;
            end
            S_SHWAIT: state_ff <= S_SHWR;
            S_SHWR: begin
               live_ff[idx_ff[AW-1:0]] <= live_ff[AW'(idx_ff - 1'b1)];
               idx_ff <= idx_ff - 1'b1; state_ff <= S_SHRD;
            end
            S_INS: begin
               live_ff[pos_ff] <= 1'b1; used_ff <= used_ff + 1'b1; state_ff <= S_RESP;
            end
            S_RESP: if (!rvalid_ff) begin
               rsp_data_ff <= {6'd0, tomb, used_ff == CW'(CAPACITY), 6'(used_ff),
                               64'(rd_ff), status_ff};
               rvalid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rvalid_ff && rsp_tready) rvalid_ff <= 1'b0;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = rsp_data_ff;
endmodule
`default_nettype wire

// ----- tb/sorted_slot_page_table_unit_test.sv -----
// testbench for the sorted slot page table: directed table, random traffic, predictor check
`default_nettype none
module sorted_slot_page_table_unit_test;

   localparam int CAP        = 32;
   localparam int RAND_ITEMS = 1000;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_DIRECTED = 14;

   typedef struct packed {
      logic [63:0] data_in;
      logic [31:0] key;
      logic [1:0]  func;
   } op_type;

   typedef struct packed {
      logic        has_tombstone;
      logic        page_full;
      logic [5:0]  entry_count;
      logic [63:0] read_data;
      logic [1:0]  status;
   } answer_type;

   typedef struct {
      op_type     op;
      logic       fixed;
      answer_type want;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;

   sorted_slot_page_table_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), // func, key, data_in
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)  // status, read_data, entry_count, page_full, has_tombstone
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // page shadow
   logic [31:0]  pg_key [CAP];
   logic [4:0]   pg_slot [CAP];
   logic         pg_live [CAP];
   logic [63:0]  pg_store [CAP];
   int           pg_used;

   answer_type   pending_answers[$];
   int           errors = 0;
   int           answers_seen = 0;
   int           idle_cycles = 0;
   bit           quiet_tail = 0;
   bit           hold_rsp = 0;
   int           st_seen[4] = '{0, 0, 0, 0};
   int           compactions = 0;

   function automatic int find_key(input logic [31:0] k, output int ins);
      int lo, hi, mid;
      lo = 0;
      hi = pg_used - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (pg_key[mid] == k) return mid;
         if (pg_key[mid] < k) lo = mid + 1;
         else hi = mid - 1;
      end
      ins = lo;
      return -1;
   endfunction

   function automatic bit any_dead();
      for (int i = 0; i < pg_used; i++)
         if (!pg_live[i]) return 1;
      return 0;
   endfunction

   function automatic void squeeze_page();
      logic [31:0] ks[CAP];
      logic [63:0] ds[CAP];
      int n;
      n = 0;
      for (int i = 0; i < pg_used; i++)
         if (pg_live[i]) begin
            ks[n] = pg_key[i];
            ds[n] = pg_store[pg_slot[i]];
            n++;
         end
      for (int i = 0; i < CAP; i++) begin
         pg_key[i]   = (i < n) ? ks[i] : '0;
         pg_store[i] = (i < n) ? ds[i] : '0;
         pg_slot[i]  = (i < n) ? 5'(i) : '0;
         pg_live[i]  = (i < n);
      end
      pg_used = n;
      compactions++;
   endfunction

   function automatic answer_type page_apply(input op_type op);
      answer_type a;
      int pos, ins;
      a = '0;
      a.status = sspt_pkg::ST_OK;
      case (sspt_pkg::func_type'(op.func))
         sspt_pkg::FUNC_READ: begin
            pos = find_key(op.key, ins);
            if (pos >= 0 && pg_live[pos]) a.read_data = pg_store[pg_slot[pos]];
            else a.status = sspt_pkg::ST_NOT_FOUND;
         end
         sspt_pkg::FUNC_DELETE: begin
            pos = find_key(op.key, ins);
            if (pos >= 0 && pg_live[pos]) pg_live[pos] = 0;
            else a.status = sspt_pkg::ST_NOT_FOUND;
         end
         sspt_pkg::FUNC_WRITE: begin
            if (pg_used >= CAP && !any_dead()) begin
               a.status = sspt_pkg::ST_FULL;
            end else begin
               if (pg_used >= CAP) squeeze_page();
               pos = find_key(op.key, ins);
               if (pos >= 0) begin
                  if (pg_live[pos]) a.status = sspt_pkg::ST_DUPLICATE;
                  else begin
                     pg_store[pg_slot[pos]] = op.data_in;
                     pg_live[pos] = 1;
                  end
               end else begin
                  for (int j = pg_used; j > ins; j--) begin
                     pg_key[j]  = pg_key[j-1];
                     pg_slot[j] = pg_slot[j-1];
                     pg_live[j] = pg_live[j-1];
                  end
                  pg_store[pg_used] = op.data_in;
                  pg_key[ins]  = op.key;
                  pg_slot[ins] = 5'(pg_used);
                  pg_live[ins] = 1;
                  pg_used++;
               end
            end
         end
         default: ;
      endcase
      a.entry_count   = 6'(pg_used);
      a.page_full     = (pg_used == CAP);
      a.has_tombstone = any_dead();
      return a;
   endfunction

   task automatic send_op(input op_type op, input logic fixed, input answer_type want);
      answer_type p;
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = page_apply(op);
      pending_answers = {pending_answers, (fixed ? want : p)};
   endtask

   // random op with keys mostly from a small pool so hits, duplicates and full pages occur
   function automatic op_type pick_op(input int pool);
      op_type op;
      int r;
      r = $urandom_range(0, 99);
      op.func = (r < 45) ? sspt_pkg::FUNC_WRITE : (r < 70) ? sspt_pkg::FUNC_READ
                : (r < 96) ? sspt_pkg::FUNC_DELETE : sspt_pkg::FUNC_NONE;
      op.key = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, pool));
      if ($urandom_range(0, 7) == 0) op.key = ~op.key;
      op.data_in = {$urandom, $urandom};
      return op;
   endfunction

   // response side
   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[73:0];
            if (pending_answers.size() == 0) begin
               $display("%0t unexpected result, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want  = pending_answers.pop_front();
               answers_seen++;
               st_seen[got.status]++;
               if (got.status !== want.status)
                  $display("%0t status mismatch: expected %0d actual %0d", $time,
                           want.status, got.status);
               if (got.read_data !== want.read_data)
                  $display("%0t read_data mismatch: expected %h actual %h", $time,
                           want.read_data, got.read_data);
               if (got.entry_count !== want.entry_count)
                  $display("%0t entry_count mismatch: expected %0d actual %0d", $time,
                           want.entry_count, got.entry_count);
               if (got.page_full !== want.page_full)
                  $display("%0t page_full mismatch: expected %b actual %b", $time,
                           want.page_full, got.page_full);
               if (got.has_tombstone !== want.has_tombstone)
                  $display("%0t has_tombstone mismatch: expected %b actual %b", $time,
                           want.has_tombstone, got.has_tombstone);
               if (got !== want) errors++;
            end
         end
         if (hold_rsp) rsp_tready <= 1'b0;
         else if (quiet_tail) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 4) != 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // long receiver stall while the sender keeps offering
   initial begin
      wait (!reset);
      repeat (600) @(posedge clock);
      hold_rsp = 1;
      repeat (400) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      directed_row_type rows[N_DIRECTED];
      answer_type none;
      op_type op;
      int pool, wait_cycles;
      none = '0;
      pg_used = 0;
      for (int i = 0; i < CAP; i++) begin
         pg_live[i] = 0; pg_key[i] = '0; pg_slot[i] = '0; pg_store[i] = '0;
      end
      // empty page: misses and a no-op typed in, the rest predicted
      rows[0]  = '{'{64'h0, 32'h0, sspt_pkg::FUNC_READ}, 1,
                   '{1'b0, 1'b0, 6'd0, 64'h0, sspt_pkg::ST_NOT_FOUND}};
      rows[1]  = '{'{64'h0, 32'hFFFF_FFFF, sspt_pkg::FUNC_DELETE}, 1,
                   '{1'b0, 1'b0, 6'd0, 64'h0, sspt_pkg::ST_NOT_FOUND}};
      rows[2]  = '{'{64'hFFFF_FFFF_FFFF_FFFF, 32'h1234, sspt_pkg::FUNC_NONE}, 1,
                   '{1'b0, 1'b0, 6'd0, 64'h0, sspt_pkg::ST_OK}};
      rows[3]  = '{'{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, sspt_pkg::FUNC_WRITE}, 0, none};
      rows[4]  = '{'{64'h0, 32'h0, sspt_pkg::FUNC_WRITE}, 0, none};
      rows[5]  = '{'{64'hA5A5_5A5A_0F0F_F0F0, 32'h8000_0000, sspt_pkg::FUNC_WRITE}, 0, none};
      rows[6]  = '{'{64'h1, 32'hFFFF_FFFF, sspt_pkg::FUNC_WRITE}, 0, none};
      rows[7]  = '{'{64'h0, 32'hFFFF_FFFF, sspt_pkg::FUNC_READ}, 0, none};
      rows[8]  = '{'{64'h0, 32'h8000_0000, sspt_pkg::FUNC_READ}, 0, none};
      rows[9]  = '{'{64'h0, 32'h0, sspt_pkg::FUNC_DELETE}, 0, none};
      rows[10] = '{'{64'h0, 32'h0, sspt_pkg::FUNC_READ}, 0, none};
      rows[11] = '{'{64'h5555_AAAA_5555_AAAA, 32'h0, sspt_pkg::FUNC_WRITE}, 0, none};
      rows[12] = '{'{64'h0, 32'h0, sspt_pkg::FUNC_READ}, 0, none};
      rows[13] = '{'{64'h0, 32'h7FFF_FFFF, sspt_pkg::FUNC_DELETE}, 0, none};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_op(rows[i].op, rows[i].fixed, rows[i].want);
      // fill to capacity, then writes to the full page, deletes and a write that compacts the page
      for (int i = 0; i < CAP; i++) begin
         op = '{{$urandom, $urandom}, 32'(100 + 3 * i), sspt_pkg::FUNC_WRITE};
         send_op(op, 0, none);
      end
      send_op('{64'h0, 32'd101, sspt_pkg::FUNC_WRITE}, 0, none);
      send_op('{64'h0, 32'd100, sspt_pkg::FUNC_WRITE}, 0, none);
      send_op('{64'h0, 32'd100, sspt_pkg::FUNC_DELETE}, 0, none);
      send_op('{64'h0, 32'd103, sspt_pkg::FUNC_DELETE}, 0, none);
      send_op('{64'hDEAD_BEEF_0000_0001, 32'd100, sspt_pkg::FUNC_WRITE}, 0, none);
      send_op('{64'h0, 32'd100, sspt_pkg::FUNC_READ}, 0, none);
      send_op('{64'h0, 32'd106, sspt_pkg::FUNC_READ}, 0, none);
      // random traffic, pool size varied so page fills and drains
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 200 == 0) pool = (n % 400 == 0) ? 40 : 200;
         if (n == RAND_ITEMS - 100) quiet_tail = 1;
         send_op(pick_op(pool), 0, none);
      end
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (pending_answers.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $display("%0d expected results never arrived", pending_answers.size());
         errors++;
      end
      $display("covered %0d results: ok %0d, not found %0d, duplicate %0d, full %0d",
               answers_seen, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
      $display("page compactions %0d, with a long receiver stall", compactions);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire
